/* src/smws_pkg.sv */
// Shared types, constants and tap tables for the skin-masked smoothing block.
package smws_pkg;

	// Geometry
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int RING_ROWS     = 8;
	localparam int WIDTH_CAP     = 1024;
	localparam int HEIGHT_CAP    = 1024;
	localparam int SIZE_MIN      = 5;
	localparam int NUM_TAPS      = 13;

	// Data widths
	localparam int PIX_W   = 25;  // skin bit, red, green, blue
	localparam int SUM_W   = 13;  // weighted channel sum, at most 25 * 255
	localparam int WSUM_W  = 5;   // sum of weights, at most 25
	localparam int SIZE_W  = 11;
	localparam int CFG_IDX_W = 3;

	// Register reset values
	localparam logic [10:0] WIDTH_RST  = 11'd512;
	localparam logic [10:0] HEIGHT_RST = 11'd512;
	localparam logic [7:0]  RED_RST    = 8'd95;
	localparam logic [7:0]  GREEN_RST  = 8'd40;
	localparam logic [7:0]  BLUE_RST   = 8'd20;
	localparam logic [7:0]  SPREAD_RST = 8'd15;
	localparam logic [7:0]  GAP_RST    = 8'd15;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_RED    = 3'd2,
		REG_GREEN  = 3'd3,
		REG_BLUE   = 3'd4,
		REG_SPREAD = 3'd5,
		REG_GAP    = 3'd6
	} reg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} state_t;

	// Tap table: row offset + 2, column offset + 2 and weight. Centre first.
	function automatic logic [2:0] tap_dr(input logic [3:0] i);
		logic [2:0] v;
		case (i)
			4'd1:                         v = 3'd0;
			4'd2, 4'd3, 4'd4:             v = 3'd1;
			4'd9, 4'd10, 4'd11:           v = 3'd3;
			4'd12:                        v = 3'd4;
			default:                      v = 3'd2;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] tap_dc(input logic [3:0] i);
		logic [2:0] v;
		case (i)
			4'd5:                         v = 3'd0;
			4'd2, 4'd6, 4'd9:             v = 3'd1;
			4'd4, 4'd7, 4'd11:            v = 3'd3;
			4'd8:                         v = 3'd4;
			default:                      v = 3'd2;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] tap_wt(input logic [3:0] i);
		logic [2:0] v;
		case (i)
			4'd0:                         v = 3'd5;
			4'd1, 4'd5, 4'd8, 4'd12:      v = 3'd1;
			default:                      v = 3'd2;
		endcase
		return v;
	endfunction

endpackage

/* src/smws_div.sv */
// Restoring divider: weighted channel sum over weight sum, one bit per cycle.
module smws_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [smws_pkg::SUM_W-1:0]   dividend,
	input  logic [smws_pkg::WSUM_W-1:0]  divisor,
	output logic                         busy,
	output logic [7:0]                   quot
);

	logic [smws_pkg::SUM_W-1:0]  dvd_q;
	logic [smws_pkg::WSUM_W-1:0] dsr_q;
	logic [smws_pkg::WSUM_W-1:0] rem_q;
	logic [3:0]                  cnt_q;
	logic [smws_pkg::WSUM_W:0]   rem_sh;
	logic                        fits;

	// One quotient bit per step
	assign rem_sh = {rem_q, dvd_q[smws_pkg::SUM_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};
	assign quot   = dvd_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 4'(smws_pkg::SUM_W - 1);
		end else if (busy) begin
			if (cnt_q == '0) begin
				busy <= 1'b0;
			end
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			rem_q <= fits ? smws_pkg::WSUM_W'(rem_sh - {1'b0, dsr_q})
				: rem_sh[smws_pkg::WSUM_W-1:0];
			dvd_q <= {dvd_q[smws_pkg::SUM_W-2:0], fits};
		end
	end

endmodule

/* src/skin_masked_weighted_smoothing.sv */
// Top level: skin classification, ring line store and 5x5 masked weighted mean.
//
//  channel  | signals                          | direction | content
//  s_*      | s_tvalid s_tready s_tdata s_tuser | in        | pixel or flush tick
//  m_*      | m_tvalid m_tready m_tdata m_tlast | out       | filtered pixel, frame end
//  cfg_*    | cfg_valid cfg_ready cfg_index cfg_data | in   | register writes
//
// One item at a time; s_tready is high only while the controller is idle. An item
// that produces no result leaves the controller idle. An item that produces a result
// goes through these steps when the centre pixel is not skin: the accepting cycle,
// 13 line store reads through the single read port, the wait on the registered read,
// a check step and the load of the output register. A skin centre adds the run of the
// bit-serial dividers before that load. The output register lets the next item be taken while
// a result waits; a new result meeting a full output register waits for m_tready.
// Reset clears control state only; the line store is not cleared.
module skin_masked_weighted_smoothing #(
	parameter int MAX_WIDTH = smws_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic        s_tuser,   // kind: 0 pixel, 1 flush
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
	output logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [smws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int DEPTH = smws_pkg::RING_ROWS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int WCAP  = MAX_WIDTH < smws_pkg::WIDTH_CAP ? MAX_WIDTH : smws_pkg::WIDTH_CAP;

	// Configuration registers
	logic [10:0] image_width_q, image_height_q;
	logic [7:0]  red_min_q, green_min_q, blue_min_q, spread_min_q, gap_min_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= smws_pkg::WIDTH_RST;
			image_height_q <= smws_pkg::HEIGHT_RST;
			red_min_q      <= smws_pkg::RED_RST;
			green_min_q    <= smws_pkg::GREEN_RST;
			blue_min_q     <= smws_pkg::BLUE_RST;
			spread_min_q   <= smws_pkg::SPREAD_RST;
			gap_min_q      <= smws_pkg::GAP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				smws_pkg::REG_WIDTH:  image_width_q  <= cfg_data;
				smws_pkg::REG_HEIGHT: image_height_q <= cfg_data;
				smws_pkg::REG_RED:    red_min_q      <= cfg_data[7:0];
				smws_pkg::REG_GREEN:  green_min_q    <= cfg_data[7:0];
				smws_pkg::REG_BLUE:   blue_min_q     <= cfg_data[7:0];
				smws_pkg::REG_SPREAD: spread_min_q   <= cfg_data[7:0];
				smws_pkg::REG_GAP:    gap_min_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Frame and position state
	smws_pkg::state_t state_q, state_d;
	logic [10:0]   frame_w_q, frame_h_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [10:0]   in_row_q;
	logic [9:0]    out_row_q;
	logic [3:0]    tap_q, tap_s1;
	logic          rd_v_s1;

	// Input decode
	logic [7:0] red, green, blue;
	logic       in_acc, is_pix, is_drain, latch, emit_go, skin;
	logic [7:0] mx, mn, rg_gap;
	logic [10:0] new_w, new_h, use_w;
	logic [11:0] col_next;

	assign red    = s_tdata[7:0];
	assign green  = s_tdata[15:8];
	assign blue   = s_tdata[23:16];
	assign in_acc = s_tvalid && s_tready;
	assign is_pix   = !s_tuser && (in_row_q < frame_h_q);
	assign is_drain = in_row_q >= frame_h_q;
	assign latch    = is_pix && (in_row_q == '0) && (in_col_q == '0);

	// Skin classification
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx)  mx = blue;
		if (green < mn) mn = green;
		if (blue < mn)  mn = blue;
		rg_gap = (red > green) ? red - green : green - red;
		skin = (red > red_min_q) && (green > green_min_q) && (blue > blue_min_q)
			&& ((mx - mn) > spread_min_q) && (rg_gap > gap_min_q)
			&& (red > green) && (red > blue);
	end

	// Frame size saturation
	always_comb begin
		new_w = image_width_q;
		if (new_w < 11'(smws_pkg::SIZE_MIN)) new_w = 11'(smws_pkg::SIZE_MIN);
		if (new_w > 11'(WCAP))               new_w = 11'(WCAP);
		new_h = image_height_q;
		if (new_h < 11'(smws_pkg::SIZE_MIN))   new_h = 11'(smws_pkg::SIZE_MIN);
		if (new_h > 11'(smws_pkg::HEIGHT_CAP)) new_h = 11'(smws_pkg::HEIGHT_CAP);
	end

	assign use_w    = latch ? new_w : frame_w_q;
	assign col_next = 12'(in_col_q) + 12'd1;
	assign emit_go  = in_acc && (is_pix
		? ((in_row_q > 11'd2) || ((in_row_q == 11'd2) && (in_col_q >= CW'(2))))
		: is_drain);

	// Tap address with edge replication
	logic signed [13:0] rs, cs;
	logic [9:0]    row_cl;
	logic [CW-1:0] col_cl;
	logic [AW-1:0] rd_addr, wr_addr;

	always_comb begin
		rs = $signed(14'(out_row_q)) + $signed(14'(smws_pkg::tap_dr(tap_q))) - 14'sd2;
		cs = $signed(14'(out_col_q)) + $signed(14'(smws_pkg::tap_dc(tap_q))) - 14'sd2;
		if (rs < 0)
			row_cl = '0;
		else if (rs > $signed(14'(frame_h_q)) - 14'sd1)
			row_cl = 10'(frame_h_q - 11'd1);
		else
			row_cl = rs[9:0];
		if (cs < 0)
			col_cl = '0;
		else if (cs > $signed(14'(frame_w_q)) - 14'sd1)
			col_cl = CW'(frame_w_q - 11'd1);
		else
			col_cl = cs[CW-1:0];
		rd_addr = AW'(row_cl[2:0]) * AW'(MAX_WIDTH) + AW'(col_cl);
		wr_addr = AW'(in_row_q[2:0]) * AW'(MAX_WIDTH) + AW'(in_col_q);
	end

	// Line store: ring of eight rows, one write and one registered read port
	logic [smws_pkg::PIX_W-1:0] mem [DEPTH];
	logic [smws_pkg::PIX_W-1:0] mem_q;
	logic mem_we;

	assign mem_we = in_acc && is_pix;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {skin, red, green, blue};
		end
		mem_q <= mem[rd_addr];
	end

	// Masked weighted accumulation
	logic [smws_pkg::SUM_W-1:0]  sr_q, sg_q, sb_q;
	logic [smws_pkg::WSUM_W-1:0] sw_q;
	logic [23:0]                 centre_q;
	logic                        centre_skin_q;
	logic [2:0]                  wt_s1;

	assign wt_s1 = smws_pkg::tap_wt(tap_s1);

	always_ff @(posedge clk) begin
		if (emit_go) begin
			sr_q <= '0;
			sg_q <= '0;
			sb_q <= '0;
			sw_q <= '0;
		end else if (rd_v_s1) begin
			if (tap_s1 == '0) begin
				centre_q      <= mem_q[23:0];
				centre_skin_q <= mem_q[24];
			end
			if (mem_q[24]) begin
				sw_q <= sw_q + smws_pkg::WSUM_W'(wt_s1);
				sr_q <= sr_q + smws_pkg::SUM_W'(wt_s1) * smws_pkg::SUM_W'(mem_q[23:16]);
				sg_q <= sg_q + smws_pkg::SUM_W'(wt_s1) * smws_pkg::SUM_W'(mem_q[15:8]);
				sb_q <= sb_q + smws_pkg::SUM_W'(wt_s1) * smws_pkg::SUM_W'(mem_q[7:0]);
			end
		end
	end

	// Dividers, one per channel
	logic       div_start;
	logic [2:0] div_busy;
	logic [7:0] q_r, q_g, q_b;

	smws_div u_div_r (.clk, .arst_n, .start(div_start), .dividend(sr_q), .divisor(sw_q),
		.busy(div_busy[0]), .quot(q_r));
	smws_div u_div_g (.clk, .arst_n, .start(div_start), .dividend(sg_q), .divisor(sw_q),
		.busy(div_busy[1]), .quot(q_g));
	smws_div u_div_b (.clk, .arst_n, .start(div_start), .dividend(sb_q), .divisor(sw_q),
		.busy(div_busy[2]), .quot(q_b));

	// Controller
	logic out_ld, last_pos;

	assign last_pos = ({1'b0, out_row_q} == frame_h_q - 11'd1)
		&& (11'(out_col_q) == frame_w_q - 11'd1);

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_ld    = 1'b0;
		unique case (state_q)
			smws_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (emit_go) state_d = smws_pkg::ST_READ;
			end
			smws_pkg::ST_READ: begin
				if (tap_q == 4'(smws_pkg::NUM_TAPS - 1)) state_d = smws_pkg::ST_LAST;
			end
			smws_pkg::ST_LAST: begin
				state_d = smws_pkg::ST_CHECK;
			end
			smws_pkg::ST_CHECK: begin
				if (centre_skin_q) begin
					div_start = 1'b1;
					state_d   = smws_pkg::ST_DIV;
				end else begin
					state_d = smws_pkg::ST_OUT;
				end
			end
			smws_pkg::ST_DIV: begin
				if (div_busy == '0) state_d = smws_pkg::ST_OUT;
			end
			smws_pkg::ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					out_ld  = 1'b1;
					state_d = smws_pkg::ST_IDLE;
				end
			end
			default: state_d = smws_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Read sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q   <= '0;
			tap_s1  <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= state_q == smws_pkg::ST_READ;
			tap_s1  <= tap_q;
			if (state_q == smws_pkg::ST_READ) begin
				tap_q <= tap_q + 4'd1;
			end else begin
				tap_q <= '0;
			end
		end
	end

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= smws_pkg::WIDTH_RST;
			frame_h_q <= smws_pkg::HEIGHT_RST;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (in_acc && is_pix) begin
				if (latch) begin
					frame_w_q <= new_w;
					frame_h_q <= new_h;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				if (col_next >= 12'(use_w)) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 11'd1;
				end else begin
					in_col_q <= CW'(col_next);
				end
			end
			if (out_ld) begin
				if (last_pos) begin
					out_col_q <= '0;
					out_row_q <= '0;
					in_col_q  <= '0;
					in_row_q  <= '0;
				end else if (11'(out_col_q) == frame_w_q - 11'd1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 10'd1;
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ld) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			m_tlast <= last_pos;
			if (centre_skin_q) begin
				m_tdata <= {q_b, q_g, q_r};
			end else begin
				m_tdata <= {centre_q[7:0], centre_q[15:8], centre_q[23:16]};
			end
		end
	end

endmodule
